// ===== rtl/core/mrr_pkg.sv =====
// Package for the multiset rank-to-groups block.
// Holds field widths, the control struct shared by the datapath units and the
// multichoose function used to build elaboration-time constants. No dependencies.
package mrr_pkg;

    localparam int unsigned RANK_W     = 34;
    localparam int unsigned GROUP_W    = 8;
    localparam int unsigned SLOT_COUNT = 5;
    localparam int unsigned SLOT_W     = 3;

    // Control from the sequencer to one datapath unit.
    typedef struct packed {
        logic load;
        logic step;
    } unit_ctrl_t;

    // Number of k-item multisets drawn from n groups, C(n+k-1, k).
    // Evaluated only on constants at elaboration.
    function automatic logic [63:0] mc_value(input logic [63:0] n, input int unsigned k);
        logic [63:0] r;
        case (k)
            0: r = 64'd1;
            1: r = n;
            2: r = n * (n + 64'd1) / 2;
            3: r = n * (n + 64'd1) * (n + 64'd2) / 6;
            4: r = n * (n + 64'd1) * (n + 64'd2) * (n + 64'd3) / 24;
            default: r = n * (n + 64'd1) * (n + 64'd2) * (n + 64'd3) * (n + 64'd4) / 120;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/mrr_in_if.sv =====
// Request channel of the multiset rank-to-groups block: valid, ready and the rank.
// Depends on mrr_pkg for the rank width.
interface mrr_in_if;
    logic                         valid;
    logic                         ready;
    logic [mrr_pkg::RANK_W-1:0]   recipe_rank;

    modport source (output valid, output recipe_rank, input ready);
    modport sink   (input valid, input recipe_rank, output ready);
endinterface

// ===== rtl/core/mrr_out_if.sv =====
// Result channel of the multiset rank-to-groups block: five group indices and a flag.
// Depends on mrr_pkg for the group width.
interface mrr_out_if;
    logic                          valid;
    logic                          ready;
    logic [mrr_pkg::GROUP_W-1:0]   group_0;
    logic [mrr_pkg::GROUP_W-1:0]   group_1;
    logic [mrr_pkg::GROUP_W-1:0]   group_2;
    logic [mrr_pkg::GROUP_W-1:0]   group_3;
    logic [mrr_pkg::GROUP_W-1:0]   group_4;
    logic                          rank_out_of_range;

    modport source (output valid, output group_0, output group_1, output group_2,
                    output group_3, output group_4, output rank_out_of_range,
                    input ready);
    modport sink   (input valid, input group_0, input group_1, input group_2,
                    input group_3, input group_4, input rank_out_of_range,
                    output ready);
endinterface

// ===== rtl/core/mrr_coef.sv =====
// Coefficient stepper: holds multichoose(n, j) for j = 1..4 and moves n down by one
// per step using Pascal's rule. Depends on mrr_pkg.
module mrr_coef #(
    parameter int unsigned GROUP_COUNT = 256,
    localparam int unsigned W1 = $clog2(mrr_pkg::mc_value(64'(GROUP_COUNT), 1) + 64'd1),
    localparam int unsigned W2 = $clog2(mrr_pkg::mc_value(64'(GROUP_COUNT), 2) + 64'd1),
    localparam int unsigned W3 = $clog2(mrr_pkg::mc_value(64'(GROUP_COUNT), 3) + 64'd1),
    localparam int unsigned W4 = $clog2(mrr_pkg::mc_value(64'(GROUP_COUNT), 4) + 64'd1)
) (
    input  logic                clk,
    input  mrr_pkg::unit_ctrl_t ctrl,
    output logic [W1-1:0]       mc1,
    output logic [W2-1:0]       mc2,
    output logic [W3-1:0]       mc3,
    output logic [W4-1:0]       mc4
);

    localparam logic [W1-1:0] INIT1 = W1'(mrr_pkg::mc_value(64'(GROUP_COUNT), 1));
    localparam logic [W2-1:0] INIT2 = W2'(mrr_pkg::mc_value(64'(GROUP_COUNT), 2));
    localparam logic [W3-1:0] INIT3 = W3'(mrr_pkg::mc_value(64'(GROUP_COUNT), 3));
    localparam logic [W4-1:0] INIT4 = W4'(mrr_pkg::mc_value(64'(GROUP_COUNT), 4));

    logic [W1-1:0] mc1_reg, mc1_next;
    logic [W2-1:0] mc2_reg, mc2_next;
    logic [W3-1:0] mc3_reg, mc3_next;
    logic [W4-1:0] mc4_reg, mc4_next;

    // mc(n-1, j) = mc(n, j) - mc(n, j-1), all terms taken at the old n.
    always_comb
    begin
        mc1_next = mc1_reg;
        mc2_next = mc2_reg;
        mc3_next = mc3_reg;
        mc4_next = mc4_reg;
        if (ctrl.load)
        begin
            mc1_next = INIT1;
            mc2_next = INIT2;
            mc3_next = INIT3;
            mc4_next = INIT4;
        end
        else if (ctrl.step)
        begin
            mc1_next = mc1_reg - W1'(1);
            mc2_next = mc2_reg - W2'(mc1_reg);
            mc3_next = mc3_reg - W3'(mc2_reg);
            mc4_next = mc4_reg - W4'(mc3_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        mc1_reg <= mc1_next;
        mc2_reg <= mc2_next;
        mc3_reg <= mc3_next;
        mc4_reg <= mc4_next;
    end

    assign mc1 = mc1_reg;
    assign mc2 = mc2_reg;
    assign mc3 = mc3_reg;
    assign mc4 = mc4_reg;

endmodule

// ===== rtl/core/mrr_csub.sv =====
// Shared compare-subtract unit: holds the remaining rank, flags when the current
// block size exceeds it, and otherwise takes the block off. Depends on mrr_pkg.
module mrr_csub #(
    parameter int unsigned CW = 36
) (
    input  logic                          clk,
    input  mrr_pkg::unit_ctrl_t           ctrl,
    input  logic [mrr_pkg::RANK_W-1:0]    rank,
    input  logic [CW-1:0]                 blk,
    output logic                          hit
);

    logic [mrr_pkg::RANK_W-1:0] rest_reg, rest_next;

    assign hit = blk > CW'(rest_reg);

    always_comb
    begin
        rest_next = rest_reg;
        if (ctrl.load)
        begin
            rest_next = rank;
        end
        else if (ctrl.step && !hit)
        begin
            // The block fits below the remaining rank, so the difference stays in range.
            rest_next = rest_reg - blk[mrr_pkg::RANK_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        rest_reg <= rest_next;
    end

endmodule

// ===== rtl/core/multiset_rank_unrank.sv =====
// Multiset rank-to-groups block: turns a rank into five group indices, non-decreasing
// for an in-range rank. The request is taken, the scan tries the candidates in turn,
// then the result register holds the groups. One request at a time; the scan loop over
// the shared compare-subtract unit sets the rate. Reset clears the sequencer, the
// output valid and the result registers. Depends on mrr_pkg and the interfaces.
module multiset_rank_unrank #(
    parameter int unsigned GROUP_COUNT = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    mrr_in_if.sink        rank_req,
    mrr_out_if.source     group_rsp
);

    localparam int unsigned W1 = $clog2(mrr_pkg::mc_value(64'(GROUP_COUNT), 1) + 64'd1);
    localparam int unsigned W2 = $clog2(mrr_pkg::mc_value(64'(GROUP_COUNT), 2) + 64'd1);
    localparam int unsigned W3 = $clog2(mrr_pkg::mc_value(64'(GROUP_COUNT), 3) + 64'd1);
    localparam int unsigned W4 = $clog2(mrr_pkg::mc_value(64'(GROUP_COUNT), 4) + 64'd1);
    localparam int unsigned CW = (W4 > mrr_pkg::RANK_W) ? W4 : mrr_pkg::RANK_W;
    localparam int unsigned MW = $clog2(GROUP_COUNT + 1);
    localparam logic [63:0] TOTAL = mrr_pkg::mc_value(64'(GROUP_COUNT), 5);
    localparam logic [mrr_pkg::SLOT_W-1:0] LAST_SLOT = mrr_pkg::SLOT_W'(mrr_pkg::SLOT_COUNT - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } state_t;

    state_t                         state_reg, state_next;
    logic [mrr_pkg::SLOT_W-1:0]     slot_reg, slot_next;
    logic [MW-1:0]                  m_reg, m_next;
    logic [mrr_pkg::GROUP_W-1:0]    groups_reg [mrr_pkg::SLOT_COUNT];
    logic [mrr_pkg::GROUP_W-1:0]    groups_next [mrr_pkg::SLOT_COUNT];
    logic                           oor_reg, oor_next;

    mrr_pkg::unit_ctrl_t coef_ctrl;
    mrr_pkg::unit_ctrl_t csub_ctrl;
    logic [W1-1:0]       mc1;
    logic [W2-1:0]       mc2;
    logic [W3-1:0]       mc3;
    logic [W4-1:0]       mc4;
    logic [CW-1:0]       blk;
    logic                hit;
    logic                at_last;

    mrr_coef #(
        .GROUP_COUNT (GROUP_COUNT)
    ) u_coef (
        .clk  (clk),
        .ctrl (coef_ctrl),
        .mc1  (mc1),
        .mc2  (mc2),
        .mc3  (mc3),
        .mc4  (mc4)
    );

    mrr_csub #(
        .CW (CW)
    ) u_csub (
        .clk  (clk),
        .ctrl (csub_ctrl),
        .rank (rank_req.recipe_rank),
        .blk  (blk),
        .hit  (hit)
    );

    // Slot s uses blocks of (4 - s)-item multisets; the last slot counts single groups.
    always_comb
    begin
        unique case (slot_reg)
            3'd0:    blk = CW'(mc4);
            3'd1:    blk = CW'(mc3);
            3'd2:    blk = CW'(mc2);
            3'd3:    blk = CW'(mc1);
            default: blk = CW'(1);
        endcase
    end

    assign at_last = (m_reg == MW'(GROUP_COUNT));

    always_comb
    begin
        state_next  = state_reg;
        slot_next   = slot_reg;
        m_next      = m_reg;
        groups_next = groups_reg;
        oor_next    = oor_reg;
        coef_ctrl   = '0;
        csub_ctrl   = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (rank_req.valid)
                begin
                    coef_ctrl.load = 1'b1;
                    csub_ctrl.load = 1'b1;
                    slot_next      = '0;
                    m_next         = MW'(1);
                    oor_next       = (64'(rank_req.recipe_rank) >= TOTAL);
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                csub_ctrl.step = 1'b1;
                if (hit)
                begin
                    // The next slot starts its scan at this candidate, so the
                    // coefficients stay where they are.
                    groups_next[slot_reg] = mrr_pkg::GROUP_W'(m_reg - MW'(1));
                end
                else if (at_last)
                begin
                    // Scan ran off the end: the slot reads zero and the next slot
                    // starts again from the first group.
                    groups_next[slot_reg] = '0;
                    m_next                = MW'(1);
                    coef_ctrl.load        = 1'b1;
                end
                else
                begin
                    m_next         = m_reg + MW'(1);
                    coef_ctrl.step = 1'b1;
                end
                if (hit || at_last)
                begin
                    if (slot_reg == LAST_SLOT)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        slot_next = slot_reg + mrr_pkg::SLOT_W'(1);
                    end
                end
            end
            ST_OUT:
            begin
                if (group_rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            slot_reg   <= '0;
            m_reg      <= '0;
            groups_reg <= '{default: '0};
            oor_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            slot_reg   <= slot_next;
            m_reg      <= m_next;
            groups_reg <= groups_next;
            oor_reg    <= oor_next;
        end
    end

    assign rank_req.ready              = (state_reg == ST_IDLE);
    assign group_rsp.valid             = (state_reg == ST_OUT);
    assign group_rsp.group_0           = groups_reg[0];
    assign group_rsp.group_1           = groups_reg[1];
    assign group_rsp.group_2           = groups_reg[2];
    assign group_rsp.group_3           = groups_reg[3];
    assign group_rsp.group_4           = groups_reg[4];
    assign group_rsp.rank_out_of_range = oor_reg;

endmodule
